// ===== sv/psts_pkg.sv =====
// psts_pkg: shared types and constants for the tick scheduler
// used by psts_cell and preemptive_srtf_priority_tick_scheduler, no dependencies
`default_nettype none

package psts_pkg;

    localparam int ARR_W  = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 17;
    localparam int PCNT_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = 17'h1FFFF;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // per-cell commands from the controller
    typedef struct packed {
        logic clear;
        logic load;
        logic dec;
    } cell_cmd_t;

    // entry written by a load request
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } load_t;

    // best candidate so far, handed down the chain
    typedef struct packed {
        logic               found;
        logic [BURST_W-1:0] rem;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [1:0]         busy_cnt;
    } cand_t;

endpackage

`default_nettype wire

// ===== sv/psts_cell.sv =====
// psts_cell: one process table slot plus one registered compare stage
// depends on psts_pkg
`default_nettype none

module psts_cell #(
    parameter int SLOTS = 16,
    parameter int INDEX = 0,
    parameter int IW    = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  psts_pkg::cell_cmd_t                  cmd,
    input  psts_pkg::load_t                      ld,
    input  wire                                  policy,
    input  wire  [psts_pkg::PCNT_W-1:0]          pcount,
    input  wire  [psts_pkg::TIME_W-1:0]          time_now,
    input  psts_pkg::cand_t                      cand_in,
    input  wire  [IW-1:0]                        idx_in,
    output psts_pkg::cand_t                      cand_out,
    output logic [IW-1:0]                        idx_out
);

    logic [psts_pkg::ARR_W-1:0]   arr_reg;
    logic [psts_pkg::BURST_W-1:0] burst_reg;
    logic [psts_pkg::BURST_W-1:0] rem_reg;
    logic [psts_pkg::PRIO_W-1:0]  prio_reg;
    psts_pkg::cand_t              cand_reg;
    psts_pkg::cand_t              cand_next;
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                idx_next;

    logic active;
    logic busy;
    logic eligible;
    logic arr_win;
    logic better;
    logic take;

    always_comb
    begin
        active   = (INDEX < SLOTS) && (INDEX < int'(pcount));
        busy     = active && (rem_reg != '0);
        eligible = busy && ({1'b0, arr_reg} <= time_now);
        arr_win  = arr_reg < cand_in.arrival;
        if (policy)
        begin
            better = (prio_reg > cand_in.prio) || ((prio_reg == cand_in.prio) && arr_win);
        end
        else
        begin
            better = (rem_reg < cand_in.rem) || ((rem_reg == cand_in.rem) && arr_win);
        end
        take = eligible && (!cand_in.found || better);

        cand_next = cand_in;
        idx_next  = idx_in;
        if (take)
        begin
            cand_next.found   = 1'b1;
            cand_next.rem     = rem_reg;
            cand_next.prio    = prio_reg;
            cand_next.arrival = arr_reg;
            cand_next.burst   = burst_reg;
            idx_next          = IW'(INDEX);
        end
        // saturating count of slots with work left
        if (busy && (cand_in.busy_cnt != 2'd2))
        begin
            cand_next.busy_cnt = cand_in.busy_cnt + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_reg   <= '0;
            burst_reg <= '0;
            rem_reg   <= '0;
            prio_reg  <= '0;
            cand_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            idx_reg  <= idx_next;
            if (cmd.clear)
            begin
                arr_reg   <= '0;
                burst_reg <= '0;
                rem_reg   <= '0;
                prio_reg  <= '0;
            end
            else if (cmd.load)
            begin
                arr_reg   <= ld.arrival;
                burst_reg <= ld.burst;
                rem_reg   <= ld.burst;
                prio_reg  <= ld.prio;
            end
            else if (cmd.dec)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

// ===== sv/preemptive_srtf_priority_tick_scheduler.sv =====
// preemptive_srtf_priority_tick_scheduler: top level, controller and chain of slot cells
// depends on psts_pkg and psts_cell
//
// Usage: requests enter on the s_axis group; tuser carries the op (load, tick, clear),
// tdata the slot, arrival, burst and priority of a load. Every request gives exactly
// one result on the m_axis group. Config registers (policy_mode at index 0,
// process_count at index 1) are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it. A request is taken
// in IDLE, a load or clear is applied at that edge, then the best-candidate record
// walks the SLOTS cells, one cell per cycle, and the result is committed from the
// DONE state once the output register is free. One request is in flight at a time,
// so no new request is taken until the last one is committed.
// The result sits in an output register; while the receiver stalls the next request
// is still taken and scanned, and its commit waits until the register is free.
// Reset clears the table, the time, both config registers and the output valid.
`default_nettype none

module preemptive_srtf_priority_tick_scheduler #(
    parameter int SLOTS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [4:0]  cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0], arrival[19:4], burst[31:20], priority_req[39:32]
    input  wire  [39:0] s_axis_tdata,
    // op[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // ran[0], ran_slot[4:1], time_now[21:5], finished[22], turnaround[39:23],
    // waiting[56:40], all_done[57], zero[63:58]
    output logic [63:0] m_axis_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = psts_pkg::TIME_W;

    typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

    state_t                         state_reg;
    logic [IW-1:0]                  cnt_reg;
    logic [1:0]                     op_reg;
    logic [TW-1:0]                  time_reg;
    logic                           policy_reg;
    logic [psts_pkg::PCNT_W-1:0]    pcount_reg;
    logic                           out_valid_reg;
    logic                           ran_reg;
    logic [3:0]                     ran_slot_reg;
    logic [TW-1:0]                  time_now_reg;
    logic                           finished_reg;
    logic [TW-1:0]                  tat_reg;
    logic [TW-1:0]                  wait_reg;
    logic                           all_done_reg;

    logic [3:0]      in_slot;
    psts_pkg::load_t in_load;
    logic            accept;
    logic            commit;
    logic            is_tick;

    psts_pkg::cand_t     chain [SLOTS+1];
    logic [IW-1:0]       idx_chain [SLOTS+1];
    psts_pkg::cand_t     last;
    logic [IW-1:0]       last_idx;
    psts_pkg::cell_cmd_t cmds [SLOTS];

    logic [TW-1:0] time_inc;
    logic [TW-1:0] arr_ext;
    logic [TW-1:0] burst_ext;
    logic [TW-1:0] tat_calc;
    logic [TW-1:0] wait_calc;
    logic          fin_calc;
    logic          ran_calc;
    logic          done_calc;

    assign in_slot         = s_axis_tdata[3:0];
    assign in_load.arrival = s_axis_tdata[19:4];
    assign in_load.burst   = s_axis_tdata[31:20];
    assign in_load.prio    = s_axis_tdata[39:32];

    assign s_axis_tready = (state_reg == IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == DONE) && (!out_valid_reg || m_axis_tready);
    assign is_tick       = (op_reg == psts_pkg::OP_TICK);

    assign chain[0]     = '0;
    assign idx_chain[0] = '0;
    assign last         = chain[SLOTS];
    assign last_idx     = idx_chain[SLOTS];

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            always_comb
            begin
                cmds[gi].clear = accept && (s_axis_tuser == psts_pkg::OP_CLEAR);
                cmds[gi].load  = accept && (s_axis_tuser == psts_pkg::OP_LOAD)
                                 && (int'(in_slot) == gi);
                cmds[gi].dec   = commit && is_tick && last.found && (last_idx == IW'(gi));
            end

            psts_cell #(
                .SLOTS (SLOTS),
                .INDEX (gi),
                .IW    (IW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmds[gi]),
                .ld       (in_load),
                .policy   (policy_reg),
                .pcount   (pcount_reg),
                .time_now (time_reg),
                .cand_in  (chain[gi]),
                .idx_in   (idx_chain[gi]),
                .cand_out (chain[gi+1]),
                .idx_out  (idx_chain[gi+1])
            );
        end
    endgenerate

    // commit arithmetic
    always_comb
    begin
        time_inc  = (time_reg == psts_pkg::TIME_MAX) ? time_reg : time_reg + 1'b1;
        arr_ext   = TW'(last.arrival);
        burst_ext = TW'(last.burst);
        ran_calc  = is_tick && last.found;
        fin_calc  = ran_calc && (last.rem == psts_pkg::BURST_W'(1));
        tat_calc  = '0;
        wait_calc = '0;
        if (fin_calc)
        begin
            tat_calc  = (time_inc >= arr_ext) ? time_inc - arr_ext : '0;
            wait_calc = (tat_calc >= burst_ext) ? tat_calc - burst_ext : '0;
        end
        if (is_tick)
        begin
            done_calc = (last.busy_cnt == 2'd0) || ((last.busy_cnt == 2'd1) && fin_calc);
        end
        else
        begin
            done_calc = (last.busy_cnt == 2'd0);
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            pcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psts_pkg::REG_POLICY: policy_reg <= cfg_data[0];
                psts_pkg::REG_COUNT:  pcount_reg <= cfg_data;
                default:              pcount_reg <= pcount_reg;
            endcase
        end
    end

    // controller, time and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            op_reg        <= psts_pkg::OP_LOAD;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            ran_reg       <= 1'b0;
            ran_slot_reg  <= '0;
            time_now_reg  <= '0;
            finished_reg  <= 1'b0;
            tat_reg       <= '0;
            wait_reg      <= '0;
            all_done_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= s_axis_tuser;
                        cnt_reg   <= '0;
                        state_reg <= SCAN;
                        if (s_axis_tuser == psts_pkg::OP_CLEAR)
                        begin
                            time_reg <= '0;
                        end
                    end
                end
                SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IW'(SLOTS - 1))
                    begin
                        state_reg <= DONE;
                    end
                end
                DONE:
                begin
                    if (commit)
                    begin
                        if (is_tick)
                        begin
                            time_reg <= time_inc;
                        end
                        ran_reg       <= ran_calc;
                        ran_slot_reg  <= ran_calc ? 4'(last_idx) : 4'd0;
                        time_now_reg  <= is_tick ? time_inc : time_reg;
                        finished_reg  <= fin_calc;
                        tat_reg       <= tat_calc;
                        wait_reg      <= wait_calc;
                        all_done_reg  <= done_calc;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, all_done_reg, wait_reg, tat_reg, finished_reg,
                            time_now_reg, ran_slot_reg, ran_reg};

    // result time matches the time register right after a commit
    a_time_match: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (m_axis_tdata[21:5] == time_reg))
        else $error("result time differs from time register");

    // a finished request always ran a slot
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[22]) |-> m_axis_tdata[0])
        else $error("finished without ran");

    // a chosen candidate is always counted among slots with work left
    a_cand_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DONE) |-> (!last.found || (last.busy_cnt != 2'd0)))
        else $error("candidate found with no busy slot");

    // no request is taken while a scan is under way
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) |=> !$past(accept))
        else $error("request taken during scan");

endmodule

`default_nettype wire
